// ----- hw/rtl/cbq_pkg.sv -----
`default_nettype none
package cbq_pkg;

  // sizes
  localparam int STAGES          = 8;
  localparam int COEFS_PER_STAGE = 5;
  localparam int COEF_FRAC       = 28;
  localparam int COEF_DEPTH      = STAGES * COEFS_PER_STAGE;
  localparam int COEF_AW         = $clog2(COEF_DEPTH);
  localparam int STAGE_W         = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int DLY_DEPTH       = STAGES * 2;
  localparam int DLY_AW          = STAGE_W + 1;
  localparam int CNT_W           = $clog2(STAGES + 1);
  localparam int ACC_W           = 40;

  localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< COEF_FRAC;

  // action codes
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // coefficient slots within a stage
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_B0,
    ST_SUM,
    ST_FIN
  } state_t;

  // multiplier data operand
  typedef enum logic [1:0] {
    SRC_DLY,
    SRC_W1,
    SRC_W2,
    SRC_W
  } mul_src_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_X_SUB,
    ACC_SUB,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic     load_x;
    mul_src_t mul_src;
    acc_op_t  acc_op;
    logic     cap_w1;
    logic     cap_w2;
    logic     cap_w;
    logic     fin_x;
  } dp_ctrl_t;

  // saturate accumulator to 32 bits, msb is the clip flag
  function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [32:0] r;
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      r = {1'b0, v[31:0]};
    end else begin
      r = {1'b1, v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return r;
  endfunction

  // saturate 32-bit data to 24 bits, msb is the clip flag
  function automatic logic [24:0] sat24(input logic signed [31:0] v);
    logic [24:0] r;
    if ((&v[31:23]) || !(|v[31:23])) begin
      r = {1'b0, v[23:0]};
    end else begin
      r = {1'b1, v[31] ? 24'h80_0000 : 24'h7f_ffff};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cbq_ram.sv -----
`default_nettype none
module cbq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cbq_coef_store.sv -----
`default_nettype none
module cbq_coef_store (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [cbq_pkg::COEF_AW-1:0]  wr_addr,
  input  wire logic signed [31:0]           wr_data,
  input  wire logic [cbq_pkg::COEF_AW-1:0]  rd_addr,
  input  wire logic                         rd_b0,
  output logic signed [31:0]                rd_data
);
  import cbq_pkg::*;

  logic [COEF_DEPTH-1:0] vld_r;
  logic [COEF_DEPTH-1:0] vld_nxt;
  logic                  vld_q_r;
  logic                  b0_q_r;
  logic [31:0]           ram_q;

  cbq_ram #(
    .DEPTH (COEF_DEPTH),
    .AW    (COEF_AW),
    .WIDTH (32)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // written marks, unwritten entries read as the transparent filter
  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // mark and slot type are registered alongside the ram read, so they line up with its data
  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[rd_addr];
    b0_q_r  <= rd_b0;
  end

  assign rd_data = vld_q_r ? signed'(ram_q) : (b0_q_r ? COEF_ONE : 32'sd0);

endmodule
`default_nettype wire

// ----- hw/rtl/cbq_delay_store.sv -----
`default_nettype none
module cbq_delay_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        clr,
  input  wire logic                        wr_en,
  input  wire logic [cbq_pkg::DLY_AW-1:0]  wr_addr,
  input  wire logic signed [31:0]          wr_data,
  input  wire logic [cbq_pkg::DLY_AW-1:0]  rd_addr,
  output logic signed [31:0]               rd_data
);
  import cbq_pkg::*;

  logic [DLY_DEPTH-1:0] vld_r;
  logic [DLY_DEPTH-1:0] vld_nxt;
  logic                 vld_q_r;
  logic [31:0]          ram_q;

  cbq_ram #(
    .DEPTH (DLY_DEPTH),
    .AW    (DLY_AW),
    .WIDTH (32)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // written marks, a clear drops them all at once
  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[rd_addr];
  end

  assign rd_data = vld_q_r ? signed'(ram_q) : 32'sd0;

endmodule
`default_nettype wire

// ----- hw/rtl/cbq_mac.sv -----
`default_nettype none
module cbq_mac (
  input  wire logic               clk,
  input  wire cbq_pkg::dp_ctrl_t  ctrl,
  input  wire logic signed [23:0] sample,
  input  wire logic signed [31:0] coef,
  input  wire logic signed [31:0] dly,
  output logic signed [31:0]      w1,
  output logic signed [31:0]      w,
  output logic signed [31:0]      x,
  output logic                    clip
);
  import cbq_pkg::*;

  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [31:0]      w1_r;
  logic signed [31:0]      w2_r;
  logic signed [31:0]      w_r;
  logic signed [31:0]      x_r;
  logic                    clip_r;
  logic signed [31:0]      mul_b;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sum;
  logic [32:0]             w_sat;
  logic [32:0]             y_sat;

  // data operand of the multiplier
  always_comb begin
    unique case (ctrl.mul_src)
      SRC_DLY: mul_b = dly;
      SRC_W1:  mul_b = w1_r;
      SRC_W2:  mul_b = w2_r;
      SRC_W:   mul_b = w_r;
      default: mul_b = dly;
    endcase
  end

  // product scaled back by the coefficient fraction, floor rounding
  assign term    = ACC_W'(signed'(prod_r[63:COEF_FRAC]));
  assign acc_sum = acc_r + term;
  assign w_sat   = sat32(acc_r);
  assign y_sat   = sat32(acc_sum);

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_X_SUB: acc_nxt = ACC_W'(x_r) - term;
      ACC_SUB:   acc_nxt = acc_r - term;
      ACC_LOAD:  acc_nxt = term;
      ACC_ADD:   acc_nxt = acc_sum;
      default:   acc_nxt = acc_r;
    endcase
  end

  // multiply register and accumulator
  always_ff @(posedge clk) begin
    prod_r <= coef * mul_b;
    acc_r  <= acc_nxt;
  end

  // stage data registers
  always_ff @(posedge clk) begin
    if (ctrl.cap_w1) begin
      w1_r <= dly;
    end
    if (ctrl.cap_w2) begin
      w2_r <= dly;
    end
    if (ctrl.cap_w) begin
      w_r <= signed'(w_sat[31:0]);
    end
    if (ctrl.load_x) begin
      x_r <= 32'(sample);
    end else if (ctrl.fin_x) begin
      x_r <= signed'(y_sat[31:0]);
    end
  end

  // sticky clip flag for the current sample
  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      clip_r <= 1'b0;
    end else if (ctrl.cap_w) begin
      clip_r <= clip_r | w_sat[32];
    end else if (ctrl.fin_x) begin
      clip_r <= clip_r | y_sat[32];
    end
  end

  assign w1   = w1_r;
  assign w    = w_r;
  assign x    = x_r;
  assign clip = clip_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cascaded_biquad_iir_filter.sv -----
`default_nettype none
// channel  direction  transfer when          payload
// in_      input      in_valid & in_ready    action, sample, last mark, coefficient write
// out_     output     out_valid & out_ready  filtered sample, last mark, saturated
// cfg_     input      cfg_wr_en              active_stages
//
// a coefficient write or a delay clear completes at its transfer
// a sample runs from transfer to result register: fetch, then for each of n active
// stages five products and a summing step, then the final step; with none, only the final step
// rst_n is synchronous; coefficients read as the transparent filter and
// delays read as zero until written
// a held result stalls only the next sample at its final step
module cascaded_biquad_iir_filter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [23:0] in_sample_in,
  input  wire logic               in_last_in_buffer,
  input  wire logic [2:0]         in_stage_select,
  input  wire logic [2:0]         in_coef_select,
  input  wire logic signed [31:0] in_coef_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_sample_out,
  output logic                    out_last_out,
  output logic                    out_saturated,
  input  wire logic               cfg_wr_en,
  input  wire logic [3:0]         cfg_wr_data
);
  import cbq_pkg::*;

  state_t             state_r;
  state_t             state_nxt;
  logic [3:0]         active_stages_r;
  logic [STAGE_W-1:0] stage_r;
  logic [STAGE_W-1:0] stage_nxt;
  logic [STAGE_W-1:0] last_stage_r;
  logic [COEF_AW-1:0] base_r;
  logic [COEF_AW-1:0] base_nxt;
  logic               last_r;
  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic               out_last_r;
  logic               out_sat_r;

  logic               accept;
  logic               out_load;
  logic [CNT_W-1:0]   n_stages;
  logic               coef_wr_en;
  logic [COEF_AW-1:0] coef_wr_addr;
  logic [COEF_AW-1:0] rd_base;
  logic [STAGE_W-1:0] rd_stage;
  logic [2:0]         coef_slot;
  logic [COEF_AW-1:0] coef_rd_addr;
  logic               dly_rd_hi;
  logic [DLY_AW-1:0]  dly_rd_addr;
  logic               dly_wr_en;
  logic               dly_wr_hi;
  logic               dly_wr_w;
  logic [DLY_AW-1:0]  dly_wr_addr;
  logic signed [31:0] dly_wr_data;
  logic               dly_clr;
  dp_ctrl_t           ctrl;

  logic signed [31:0] coef_q;
  logic signed [31:0] dly_q;
  logic signed [31:0] dp_w1;
  logic signed [31:0] dp_w;
  logic signed [31:0] dp_x;
  logic               dp_clip;
  logic [24:0]        out_sat;

  assign accept = in_valid && in_ready;

  // stages in use, capped at the built depth
  assign n_stages = (32'(active_stages_r) > STAGES) ? CNT_W'(STAGES) : CNT_W'(active_stages_r);

  // coefficient write on transfer, out of range writes dropped
  assign coef_wr_en   = accept && (in_action == ACT_WRITE)
                        && (32'(in_stage_select) < STAGES) && (in_coef_select <= COEF_A2);
  assign coef_wr_addr = COEF_AW'(32'(in_stage_select) * COEFS_PER_STAGE
                                 + 32'(in_coef_select));
  assign dly_clr      = accept && (in_action == ACT_CLEAR);

  // sequencer: next state, memory addresses and datapath controls
  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    base_nxt      = base_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    rd_base       = base_r;
    rd_stage      = stage_r;
    coef_slot     = COEF_A1;
    dly_rd_hi     = 1'b0;
    dly_wr_en     = 1'b0;
    dly_wr_hi     = 1'b0;
    dly_wr_w      = 1'b0;
    ctrl          = '0;
    ctrl.mul_src  = SRC_DLY;
    ctrl.acc_op   = ACC_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        stage_nxt = '0;
        base_nxt  = '0;
        if (in_valid && (in_action == ACT_FILTER)) begin
          ctrl.load_x = 1'b1;
          state_nxt   = (n_stages == '0) ? ST_FIN : ST_FETCH;
        end
      end
      ST_FETCH: begin
        coef_slot = COEF_A1;
        state_nxt = ST_A1;
      end
      ST_A1: begin
        ctrl.mul_src = SRC_DLY;
        ctrl.cap_w1  = 1'b1;
        coef_slot    = COEF_A2;
        dly_rd_hi    = 1'b1;
        state_nxt    = ST_A2;
      end
      ST_A2: begin
        ctrl.mul_src = SRC_DLY;
        ctrl.cap_w2  = 1'b1;
        ctrl.acc_op  = ACC_X_SUB;
        coef_slot    = COEF_B1;
        state_nxt    = ST_B1;
      end
      ST_B1: begin
        ctrl.mul_src = SRC_W1;
        ctrl.acc_op  = ACC_SUB;
        coef_slot    = COEF_B2;
        state_nxt    = ST_B2;
      end
      ST_B2: begin
        ctrl.mul_src = SRC_W2;
        ctrl.cap_w   = 1'b1;
        ctrl.acc_op  = ACC_LOAD;
        coef_slot    = COEF_B0;
        dly_wr_en    = 1'b1;
        dly_wr_hi    = 1'b1;
        state_nxt    = ST_B0;
      end
      ST_B0: begin
        ctrl.mul_src = SRC_W;
        ctrl.acc_op  = ACC_ADD;
        dly_wr_en    = 1'b1;
        dly_wr_w     = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        ctrl.fin_x = 1'b1;
        if (stage_r == last_stage_r) begin
          state_nxt = ST_FIN;
        end else begin
          // overlap the first reads of the next stage
          rd_base   = base_r + COEF_AW'(COEFS_PER_STAGE);
          rd_stage  = stage_r + STAGE_W'(1);
          coef_slot = COEF_A1;
          stage_nxt = rd_stage;
          base_nxt  = rd_base;
          state_nxt = ST_A1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign coef_rd_addr = rd_base + COEF_AW'(coef_slot);
  assign dly_rd_addr  = {rd_stage, dly_rd_hi};
  assign dly_wr_addr  = {stage_r, dly_wr_hi};
  assign dly_wr_data  = dly_wr_w ? dp_w : dp_w1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      active_stages_r <= 4'd1;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        active_stages_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage position and per sample data
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    base_r  <= base_nxt;
    if (accept) begin
      last_r       <= in_last_in_buffer;
      last_stage_r <= STAGE_W'(n_stages - CNT_W'(1));
    end
  end

  // result register
  assign out_sat = sat24(dp_x);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= signed'(out_sat[23:0]);
      out_last_r   <= last_r;
      out_sat_r    <= dp_clip | out_sat[24];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;
  assign out_saturated  = out_sat_r;

  cbq_coef_store u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr_en),
    .wr_addr (coef_wr_addr),
    .wr_data (in_coef_value),
    .rd_addr (coef_rd_addr),
    .rd_b0   (coef_slot == COEF_B0),
    .rd_data (coef_q)
  );

  cbq_delay_store u_dly (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (dly_clr),
    .wr_en   (dly_wr_en),
    .wr_addr (dly_wr_addr),
    .wr_data (dly_wr_data),
    .rd_addr (dly_rd_addr),
    .rd_data (dly_q)
  );

  cbq_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (in_sample_in),
    .coef   (coef_q),
    .dly    (dly_q),
    .w1     (dp_w1),
    .w      (dp_w),
    .x      (dp_x),
    .clip   (dp_clip)
  );

endmodule
`default_nettype wire
